[rtl/blr_pkg.sv]
package blr_pkg;

  // Coordinate bits taken from the inputs; higher bits follow the sign.
  localparam int COORD_BITS = 16;

  // Port and state widths.
  localparam int PIX_W   = 16;
  localparam int COLOR_W = 16;
  localparam int DIM_W   = 13;
  localparam int SPAN_W  = PIX_W + 1;
  localparam int NSPAN_W = PIX_W + 2;
  localparam int ERR_W   = PIX_W + 3;
  localparam int ERR2_W  = ERR_W + 1;

  // Queue between the front and the back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 13'd320;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

  // Command codes.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // One classified command, with the line setup already worked out for a start.
  typedef struct packed {
    logic                      cmd;
    logic signed [PIX_W-1:0]   x0;
    logic signed [PIX_W-1:0]   y0;
    logic signed [PIX_W-1:0]   x1;
    logic signed [PIX_W-1:0]   y1;
    logic [COLOR_W-1:0]        color;
    logic [SPAN_W-1:0]         span_x;
    logic signed [NSPAN_W-1:0] neg_span_y;
    logic                      step_x_neg;
    logic                      step_y_neg;
    logic signed [ERR_W-1:0]   err;
  } blr_item_t;

  // Keep the low COORD_BITS bits of a coordinate and sign-extend them.
  function automatic logic signed [PIX_W-1:0] coord_in(input logic [PIX_W-1:0] v);
    logic [PIX_W-1:0] r;
    r = v;
    for (int i = COORD_BITS; i < PIX_W; i++) begin
      r[i] = v[COORD_BITS-1];
    end
    return $signed(r);
  endfunction

endpackage

[rtl/blr_front.sv]
module blr_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic signed [blr_pkg::PIX_W-1:0] in_start_x,
  input  logic signed [blr_pkg::PIX_W-1:0] in_start_y,
  input  logic signed [blr_pkg::PIX_W-1:0] in_end_x,
  input  logic signed [blr_pkg::PIX_W-1:0] in_end_y,
  input  logic [blr_pkg::COLOR_W-1:0]     in_pixel_color,
  output logic                            deq_valid,
  input  logic                            deq_ready,
  output blr_pkg::blr_item_t              deq_item
);

  logic signed [blr_pkg::PIX_W-1:0]   x0, y0, x1, y1;
  logic signed [blr_pkg::SPAN_W-1:0]  dx, ndx, dy, ndy, nsy;
  logic [blr_pkg::SPAN_W-1:0]         span_x;
  logic signed [blr_pkg::NSPAN_W-1:0] neg_span_y;
  blr_pkg::blr_item_t                 item;

  blr_pkg::blr_item_t               q_r [blr_pkg::QDEPTH];
  logic [blr_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [blr_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [blr_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                             push, pop;

  // Line setup: spans, step directions and the first error term.
  always_comb begin
    x0  = blr_pkg::coord_in(in_start_x);
    y0  = blr_pkg::coord_in(in_start_y);
    x1  = blr_pkg::coord_in(in_end_x);
    y1  = blr_pkg::coord_in(in_end_y);
    dx  = $signed({x1[blr_pkg::PIX_W-1], x1}) - $signed({x0[blr_pkg::PIX_W-1], x0});
    ndx = $signed({x0[blr_pkg::PIX_W-1], x0}) - $signed({x1[blr_pkg::PIX_W-1], x1});
    dy  = $signed({y1[blr_pkg::PIX_W-1], y1}) - $signed({y0[blr_pkg::PIX_W-1], y0});
    ndy = $signed({y0[blr_pkg::PIX_W-1], y0}) - $signed({y1[blr_pkg::PIX_W-1], y1});
    span_x     = dx[blr_pkg::SPAN_W-1] ? ndx : dx;
    nsy        = dy[blr_pkg::SPAN_W-1] ? dy : ndy;
    neg_span_y = blr_pkg::NSPAN_W'(nsy);

    item.cmd        = in_command;
    item.x0         = x0;
    item.y0         = y0;
    item.x1         = x1;
    item.y1         = y1;
    item.color      = in_pixel_color;
    item.span_x     = span_x;
    item.neg_span_y = neg_span_y;
    item.step_x_neg = dx[blr_pkg::SPAN_W-1] || (dx == '0);
    item.step_y_neg = dy[blr_pkg::SPAN_W-1] || (dy == '0);
    item.err        = $signed({{(blr_pkg::ERR_W-blr_pkg::SPAN_W){1'b0}}, span_x})
                    + blr_pkg::ERR_W'(neg_span_y);
  end

  // Queue handshake.
  assign in_ready  = (count_r != blr_pkg::QCNT_W'(blr_pkg::QDEPTH));
  assign deq_valid = (count_r != '0);
  assign deq_item  = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = deq_valid && deq_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

[rtl/blr_back.sv]
module blr_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [blr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [blr_pkg::DIM_W-1:0]         cfg_wdata,
  input  logic                              deq_valid,
  output logic                              deq_ready,
  input  blr_pkg::blr_item_t                deq_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_point_valid,
  output logic                              out_on_screen,
  output logic signed [blr_pkg::PIX_W-1:0]  out_pixel_x,
  output logic signed [blr_pkg::PIX_W-1:0]  out_pixel_y,
  output logic [blr_pkg::COLOR_W-1:0]       out_color,
  output logic                              out_last_point
);

  // Screen size.
  logic [blr_pkg::DIM_W-1:0] screen_width_r, screen_height_r;

  // Line state.
  logic                               line_active_r, line_active_nxt;
  logic signed [blr_pkg::PIX_W-1:0]   cur_x_r, cur_y_r, target_x_r, target_y_r;
  logic [blr_pkg::SPAN_W-1:0]         span_x_r;
  logic signed [blr_pkg::NSPAN_W-1:0] neg_span_y_r;
  logic                               step_x_neg_r, step_y_neg_r;
  logic signed [blr_pkg::ERR_W-1:0]   err_r;
  logic [blr_pkg::COLOR_W-1:0]        color_r;

  // Result register.
  logic                               out_valid_r;
  logic                               out_point_valid_r, out_point_valid_nxt;
  logic                               out_on_screen_r, out_on_screen_nxt;
  logic signed [blr_pkg::PIX_W-1:0]   out_pixel_x_r, out_pixel_x_nxt;
  logic signed [blr_pkg::PIX_W-1:0]   out_pixel_y_r, out_pixel_y_nxt;
  logic [blr_pkg::COLOR_W-1:0]        out_color_r, out_color_nxt;
  logic                               out_last_point_r, out_last_point_nxt;

  // Working values.
  logic                               pop, is_start, move_x, move_y, last;
  logic signed [blr_pkg::ERR2_W-1:0]  e2, n_e2;
  logic signed [blr_pkg::PIX_W-1:0]   step_x, step_y;
  logic signed [blr_pkg::ERR_W-1:0]   step_err;
  logic signed [blr_pkg::PIX_W-1:0]   n_x, n_y, n_tx, n_ty;
  logic [blr_pkg::SPAN_W-1:0]         n_sx;
  logic signed [blr_pkg::NSPAN_W-1:0] n_nsy;
  logic                               n_sxn, n_syn;
  logic signed [blr_pkg::ERR_W-1:0]   n_err;
  logic [blr_pkg::COLOR_W-1:0]        n_color;

  assign deq_ready = !out_valid_r || out_ready;
  assign pop       = deq_valid && deq_ready;
  assign is_start  = (deq_item.cmd == blr_pkg::CMD_START);

  // One Bresenham step from the held state.
  always_comb begin
    e2     = {err_r, 1'b0};
    move_x = (e2 >= blr_pkg::ERR2_W'(neg_span_y_r));
    move_y = (e2 <= $signed({{(blr_pkg::ERR2_W-blr_pkg::SPAN_W){1'b0}}, span_x_r}));
    step_err = err_r
             + (move_x ? blr_pkg::ERR_W'(neg_span_y_r) : '0)
             + (move_y ? $signed({{(blr_pkg::ERR_W-blr_pkg::SPAN_W){1'b0}}, span_x_r})
                       : '0);
    step_x = cur_x_r;
    if (move_x) begin
      step_x = step_x_neg_r ? cur_x_r - blr_pkg::PIX_W'(1) : cur_x_r + blr_pkg::PIX_W'(1);
    end
    step_y = cur_y_r;
    if (move_y) begin
      step_y = step_y_neg_r ? cur_y_r - blr_pkg::PIX_W'(1) : cur_y_r + blr_pkg::PIX_W'(1);
    end
  end

  // New line state: loaded from a start, or stepped on an advance.
  always_comb begin
    if (is_start) begin
      n_x     = deq_item.x0;
      n_y     = deq_item.y0;
      n_tx    = deq_item.x1;
      n_ty    = deq_item.y1;
      n_sx    = deq_item.span_x;
      n_nsy   = deq_item.neg_span_y;
      n_sxn   = deq_item.step_x_neg;
      n_syn   = deq_item.step_y_neg;
      n_err   = deq_item.err;
      n_color = deq_item.color;
    end else begin
      n_x     = step_x;
      n_y     = step_y;
      n_tx    = target_x_r;
      n_ty    = target_y_r;
      n_sx    = span_x_r;
      n_nsy   = neg_span_y_r;
      n_sxn   = step_x_neg_r;
      n_syn   = step_y_neg_r;
      n_err   = step_err;
      n_color = color_r;
    end
  end

  // Last point: at the end, or the next step would move an axis already on target.
  always_comb begin
    n_e2 = {n_err, 1'b0};
    last = ((n_x == n_tx) && (n_y == n_ty))
        || ((n_e2 >= blr_pkg::ERR2_W'(n_nsy)) && (n_x == n_tx))
        || ((n_e2 <= $signed({{(blr_pkg::ERR2_W-blr_pkg::SPAN_W){1'b0}}, n_sx}))
            && (n_y == n_ty));
  end

  // Result fields; an advance with no line gives an empty last beat.
  always_comb begin
    out_point_valid_nxt = is_start || line_active_r;
    if (out_point_valid_nxt) begin
      out_on_screen_nxt  = !n_x[blr_pkg::PIX_W-1] && !n_y[blr_pkg::PIX_W-1]
                        && (n_x < $signed({1'b0, (blr_pkg::PIX_W-1)'(screen_width_r)}))
                        && (n_y < $signed({1'b0, (blr_pkg::PIX_W-1)'(screen_height_r)}));
      out_pixel_x_nxt    = n_x;
      out_pixel_y_nxt    = n_y;
      out_color_nxt      = n_color;
      out_last_point_nxt = last;
      line_active_nxt    = !last;
    end else begin
      out_on_screen_nxt  = 1'b0;
      out_pixel_x_nxt    = '0;
      out_pixel_y_nxt    = '0;
      out_color_nxt      = '0;
      out_last_point_nxt = 1'b1;
      line_active_nxt    = 1'b0;
    end
  end

  // Control state and the result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (pop) begin
        line_active_r <= line_active_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Line payload and result payload.
  always_ff @(posedge clk) begin
    if (pop && out_point_valid_nxt) begin
      cur_x_r      <= n_x;
      cur_y_r      <= n_y;
      target_x_r   <= n_tx;
      target_y_r   <= n_ty;
      span_x_r     <= n_sx;
      neg_span_y_r <= n_nsy;
      step_x_neg_r <= n_sxn;
      step_y_neg_r <= n_syn;
      err_r        <= n_err;
      color_r      <= n_color;
    end
    if (pop) begin
      out_point_valid_r <= out_point_valid_nxt;
      out_on_screen_r   <= out_on_screen_nxt;
      out_pixel_x_r     <= out_pixel_x_nxt;
      out_pixel_y_r     <= out_pixel_y_nxt;
      out_color_r       <= out_color_nxt;
      out_last_point_r  <= out_last_point_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= blr_pkg::SCREEN_WIDTH_RST;
      screen_height_r <= blr_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        blr_pkg::CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        blr_pkg::CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_valid = out_point_valid_r;
  assign out_on_screen   = out_on_screen_r;
  assign out_pixel_x     = out_pixel_x_r;
  assign out_pixel_y     = out_pixel_y_r;
  assign out_color       = out_color_r;
  assign out_last_point  = out_last_point_r;

`ifndef NO_ASSERTIONS
  // A popped command always lands in the result register.
  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r)
    else $error("popped command did not produce a result");

  // A held result blocks the queue.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !pop)
    else $error("queue popped while result stalled");

  // An advance with no line gives an empty last beat.
  a_idle_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !is_start && !line_active_r) |=> (!out_point_valid_r && out_last_point_r))
    else $error("advance without a line gave a point");

  // A line ends with its last point.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && out_last_point_nxt) |=> !line_active_r)
    else $error("line still active after its last point");
`endif

endmodule

[rtl/bresenham_line_rasterizer.sv]
// Line rasterizer: all-octant integer Bresenham line drawing.
// Input channel (in_valid/in_ready): in_command selects a start (load the
// endpoints and color and return the first point) or an advance (return the
// next point). Every accepted beat yields exactly one result beat.
// Result channel (out_valid/out_ready): point, color, on-screen flag and the
// last-point mark. An advance with no active line returns a beat with
// out_point_valid and out_on_screen low and out_last_point high.
// Configuration: cfg_we writes cfg_wdata into the register chosen by cfg_index
// (0 screen width, 1 screen height); write only while the block is idle.
// Path: the line setup is done as the beat enters the queue, and the stepping
// engine takes the beat from the queue and loads the result register.
// Throughput: one beat per cycle while the result side does not stall, set by
// the error update and coordinate step that the engine makes together.
// Reset (rst_n, synchronous): no line active, queue and result register empty,
// screen size 320 by 480.
// Stall: the result register holds while out_ready is low; the two-entry queue
// keeps taking beats until it is full, then in_ready drops.
module bresenham_line_rasterizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [blr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [blr_pkg::DIM_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic signed [blr_pkg::PIX_W-1:0]  in_start_x,
  input  logic signed [blr_pkg::PIX_W-1:0]  in_start_y,
  input  logic signed [blr_pkg::PIX_W-1:0]  in_end_x,
  input  logic signed [blr_pkg::PIX_W-1:0]  in_end_y,
  input  logic [blr_pkg::COLOR_W-1:0]       in_pixel_color,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_point_valid,
  output logic                              out_on_screen,
  output logic signed [blr_pkg::PIX_W-1:0]  out_pixel_x,
  output logic signed [blr_pkg::PIX_W-1:0]  out_pixel_y,
  output logic [blr_pkg::COLOR_W-1:0]       out_color,
  output logic                              out_last_point
);

  logic               deq_valid, deq_ready;
  blr_pkg::blr_item_t deq_item;

  // Front: setup and queue.
  blr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_pixel_color (in_pixel_color),
    .deq_valid      (deq_valid),
    .deq_ready      (deq_ready),
    .deq_item       (deq_item)
  );

  // Back: stepping engine and result register.
  blr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .deq_valid       (deq_valid),
    .deq_ready       (deq_ready),
    .deq_item        (deq_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_valid (out_point_valid),
    .out_on_screen   (out_on_screen),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_color       (out_color),
    .out_last_point  (out_last_point)
  );

endmodule

[sim/tb_bresenham_line_rasterizer.sv]
`timescale 1ns / 100ps

module tb_bresenham_line_rasterizer;

  localparam int HALF_PERIOD   = 4;
  localparam int HANG_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int NUM_PHASES    = 7;
  localparam int PHASE_ITEMS   = 170;
  localparam int IDLE_PCT      = 25;
  localparam int COORD_MIN     = -32768;
  localparam int COORD_MAX     = 32767;

  // One point as it leaves the rasterizer.
  typedef struct {
    logic                             point_valid;
    logic                             on_screen;
    logic signed [blr_pkg::PIX_W-1:0] x;
    logic signed [blr_pkg::PIX_W-1:0] y;
    logic [blr_pkg::COLOR_W-1:0]      color;
    logic                             last;
  } raster_point_t;

  // One command beat on the input channel.
  typedef struct {
    logic                             command;
    logic signed [blr_pkg::PIX_W-1:0] sx;
    logic signed [blr_pkg::PIX_W-1:0] sy;
    logic signed [blr_pkg::PIX_W-1:0] ex;
    logic signed [blr_pkg::PIX_W-1:0] ey;
    logic [blr_pkg::COLOR_W-1:0]      color;
  } line_cmd_t;

  // A directed step; the point is used only where it is typed in.
  typedef struct {
    line_cmd_t     cmd;
    bit            typed;
    raster_point_t point;
  } plan_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [blr_pkg::CFG_IDX_W-1:0]    cfg_index = blr_pkg::CFG_SCREEN_WIDTH;
  logic [blr_pkg::DIM_W-1:0]        cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             in_command = blr_pkg::CMD_ADVANCE;
  logic signed [blr_pkg::PIX_W-1:0] in_start_x = '0;
  logic signed [blr_pkg::PIX_W-1:0] in_start_y = '0;
  logic signed [blr_pkg::PIX_W-1:0] in_end_x = '0;
  logic signed [blr_pkg::PIX_W-1:0] in_end_y = '0;
  logic [blr_pkg::COLOR_W-1:0]      in_pixel_color = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b1;
  logic                             out_point_valid;
  logic                             out_on_screen;
  logic signed [blr_pkg::PIX_W-1:0] out_pixel_x;
  logic signed [blr_pkg::PIX_W-1:0] out_pixel_y;
  logic [blr_pkg::COLOR_W-1:0]      out_color;
  logic                             out_last_point;

  // Line tracer state, a private copy of what the block holds.
  bit                          tr_active = 1'b0;
  int                          tr_x = 0;
  int                          tr_y = 0;
  int                          tr_tx = 0;
  int                          tr_ty = 0;
  int                          tr_span_x = 0;
  int                          tr_nspan_y = 0;
  bit                          tr_xneg = 1'b0;
  bit                          tr_yneg = 1'b0;
  int                          tr_err = 0;
  logic [blr_pkg::COLOR_W-1:0] tr_color = '0;
  int                          scr_w = 320;
  int                          scr_h = 480;

  raster_point_t pending_points[$];
  raster_point_t blank_point = '{1'b0, 1'b0, '0, '0, '0, 1'b1};
  plan_row_t     plan[$];
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles = 0;
  bit            steady = 1'b0;

  int phase_w [NUM_PHASES] = '{320, 0, 1, 4096, 8191, 97, 640};
  int phase_h [NUM_PHASES] = '{480, 4096, 1, 0, 8191, 53, 2};

  bresenham_line_rasterizer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_pixel_color  (in_pixel_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_valid (out_point_valid),
    .out_on_screen   (out_on_screen),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_color       (out_color),
    .out_last_point  (out_last_point)
  );

  // Free-running clock.
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Trace one command through the line state and return the point it yields.
  function automatic raster_point_t trace_line(line_cmd_t c);
    raster_point_t p;
    int            dx;
    int            dy;
    int            e2;
    p.point_valid = 1'b0;
    p.on_screen   = 1'b0;
    p.x           = '0;
    p.y           = '0;
    p.color       = '0;
    p.last        = 1'b1;
    if (c.command == blr_pkg::CMD_START) begin
      tr_x       = c.sx;
      tr_y       = c.sy;
      tr_tx      = c.ex;
      tr_ty      = c.ey;
      dx         = tr_tx - tr_x;
      dy         = tr_ty - tr_y;
      tr_span_x  = (dx < 0) ? -dx : dx;
      tr_nspan_y = (dy < 0) ? dy : -dy;
      tr_xneg    = !(tr_x < tr_tx);
      tr_yneg    = !(tr_y < tr_ty);
      tr_err     = tr_span_x + tr_nspan_y;
      tr_color   = c.color;
      tr_active  = 1'b1;
    end else if (!tr_active) begin
      return p;
    end else begin
      e2 = 2 * tr_err;
      if (e2 >= tr_nspan_y) begin
        tr_err += tr_nspan_y;
        tr_x   += tr_xneg ? -1 : 1;
      end
      if (e2 <= tr_span_x) begin
        tr_err += tr_span_x;
        tr_y   += tr_yneg ? -1 : 1;
      end
    end
    // The line also ends when the next step would push an axis past its target.
    e2 = 2 * tr_err;
    p.last = (tr_x == tr_tx && tr_y == tr_ty) ||
             (e2 >= tr_nspan_y && tr_x == tr_tx) ||
             (e2 <= tr_span_x && tr_y == tr_ty);
    p.point_valid = 1'b1;
    p.on_screen   = tr_x >= 0 && tr_y >= 0 && tr_x < scr_w && tr_y < scr_h;
    p.x           = tr_x[blr_pkg::PIX_W-1:0];
    p.y           = tr_y[blr_pkg::PIX_W-1:0];
    p.color       = tr_color;
    if (p.last)
      tr_active = 1'b0;
    return p;
  endfunction

  // Build one directed step.
  function automatic plan_row_t row(logic cmd, int sx, int sy, int ex, int ey, int color,
                                    bit typed, logic pv, logic on, int px, int py, int pc,
                                    logic last);
    plan_row_t r;
    r.cmd.command     = cmd;
    r.cmd.sx          = sx[blr_pkg::PIX_W-1:0];
    r.cmd.sy          = sy[blr_pkg::PIX_W-1:0];
    r.cmd.ex          = ex[blr_pkg::PIX_W-1:0];
    r.cmd.ey          = ey[blr_pkg::PIX_W-1:0];
    r.cmd.color       = color[blr_pkg::COLOR_W-1:0];
    r.typed           = typed;
    r.point.point_valid = pv;
    r.point.on_screen = on;
    r.point.x         = px[blr_pkg::PIX_W-1:0];
    r.point.y         = py[blr_pkg::PIX_W-1:0];
    r.point.color     = pc[blr_pkg::COLOR_W-1:0];
    r.point.last      = last;
    return r;
  endfunction

  // An advance whose point comes from the tracer.
  function automatic plan_row_t adv_row();
    return row(blr_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 0, 0, 0, 1'b0);
  endfunction

  // Random coordinate: near the origin, near the screen edge, or anywhere.
  function automatic logic signed [blr_pkg::PIX_W-1:0] pick_coord(int lim);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = int'($urandom_range(0, 24)) - 8;
      5, 6, 7:       v = lim + int'($urandom_range(0, 16)) - 8;
      8:             v = int'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       v = COORD_MIN;
          1:       v = COORD_MAX;
          2:       v = -1;
          default: v = 0;
        endcase
      end
    endcase
    return v[blr_pkg::PIX_W-1:0];
  endfunction

  // Random end point, mostly a short hop from the start.
  function automatic logic signed [blr_pkg::PIX_W-1:0] pick_end(
      logic signed [blr_pkg::PIX_W-1:0] s, int lim);
    int v;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70)
      v = int'(s) + int'($urandom_range(0, 24)) - 12;
    else if (roll < 85)
      v = int'(s) + int'($urandom_range(0, 80)) - 40;
    else
      v = int'(pick_coord(lim));
    return v[blr_pkg::PIX_W-1:0];
  endfunction

  // Drive one beat, wait for it to be taken and record the point it must yield.
  task automatic send_beat(line_cmd_t c, bit typed, raster_point_t given);
    raster_point_t traced;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= c.command;
    in_start_x     <= c.sx;
    in_start_y     <= c.sy;
    in_end_x       <= c.ex;
    in_end_y       <= c.ey;
    in_pixel_color <= c.color;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    traced = trace_line(c);
    pending_points.push_back(typed ? given : traced);
  endtask

  // Let every outstanding point come out, then give the pipeline time to empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_points.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program the screen size; only called while the block is idle.
  task automatic set_screen(int w, int h);
    cfg_we    <= 1'b1;
    cfg_index <= blr_pkg::CFG_SCREEN_WIDTH;
    cfg_wdata <= w[blr_pkg::DIM_W-1:0];
    @(posedge clk);
    cfg_index <= blr_pkg::CFG_SCREEN_HEIGHT;
    cfg_wdata <= h[blr_pkg::DIM_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = w & ((1 << blr_pkg::DIM_W) - 1);
    scr_h = h & ((1 << blr_pkg::DIM_W) - 1);
  endtask

  // Random lines: mostly drawn to their end, some cut short, some stray advances.
  task automatic play_phase(int unsigned n_items, int lim_w, int lim_h);
    line_cmd_t   c;
    int unsigned sent;
    int          cap;
    int          k;
    sent = 0;
    while (sent < n_items) begin
      c.command = blr_pkg::CMD_ADVANCE;
      c.sx      = blr_pkg::PIX_W'($urandom);
      c.sy      = blr_pkg::PIX_W'($urandom);
      c.ex      = blr_pkg::PIX_W'($urandom);
      c.ey      = blr_pkg::PIX_W'($urandom);
      c.color   = blr_pkg::COLOR_W'($urandom);
      if ($urandom_range(0, 99) < 8) begin
        send_beat(c, 1'b0, blank_point);
        sent++;
      end else begin
        c.command = blr_pkg::CMD_START;
        c.sx      = pick_coord(lim_w);
        c.sy      = pick_coord(lim_h);
        c.ex      = pick_end(c.sx, lim_w);
        c.ey      = pick_end(c.sy, lim_h);
        send_beat(c, 1'b0, blank_point);
        sent++;
        c.command = blr_pkg::CMD_ADVANCE;
        cap = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 3) : $urandom_range(20, 60);
        k = 0;
        while (tr_active && k < cap) begin
          send_beat(c, 1'b0, blank_point);
          sent++;
          k++;
        end
        if ($urandom_range(0, 4) == 0) begin
          send_beat(c, 1'b0, blank_point);
          sent++;
        end
      end
    end
  endtask

  // Compare one result beat with the oldest expected point.
  task automatic check_point(raster_point_t want);
    if (out_point_valid !== want.point_valid) begin
      $error("point_valid: expected %0d, got %0d", want.point_valid, out_point_valid);
      mismatch_count++;
    end
    if (out_on_screen !== want.on_screen) begin
      $error("on_screen: expected %0d, got %0d", want.on_screen, out_on_screen);
      mismatch_count++;
    end
    if (out_pixel_x !== want.x) begin
      $error("pixel_x: expected %0d, got %0d", want.x, out_pixel_x);
      mismatch_count++;
    end
    if (out_pixel_y !== want.y) begin
      $error("pixel_y: expected %0d, got %0d", want.y, out_pixel_y);
      mismatch_count++;
    end
    if (out_color !== want.color) begin
      $error("out_color: expected %h, got %h", want.color, out_color);
      mismatch_count++;
    end
    if (out_last_point !== want.last) begin
      $error("last_point: expected %0d, got %0d", want.last, out_last_point);
      mismatch_count++;
    end
  endtask

  // Result side: check each beat and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $error("result beat with no point expected");
        mismatch_count++;
      end else begin
        check_point(pending_points.pop_front());
      end
    end
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: too long without a beat on either channel means the block hangs.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == HANG_LIMIT) begin
        $display("[bresenham_line_rasterizer] ERROR");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    // Directed steps at the reset screen size of 320 by 480.
    plan.push_back(row(blr_pkg::CMD_ADVANCE, -1, -1, -1, -1, 'hFFFF, 1, 0, 0, 0, 0, 0, 1));
    plan.push_back(row(blr_pkg::CMD_START, 5, 7, 5, 7, 'hFFFF, 1, 1, 1, 5, 7, 'hFFFF, 1));
    plan.push_back(row(blr_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1));
    plan.push_back(row(blr_pkg::CMD_START, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                       'h0000, 1, 1, 0, COORD_MIN, COORD_MIN, 'h0000, 0));
    plan.push_back(adv_row());
    plan.push_back(row(blr_pkg::CMD_START, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                       'hAAAA, 1, 1, 0, COORD_MAX, COORD_MIN, 'hAAAA, 0));
    plan.push_back(adv_row());
    plan.push_back(row(blr_pkg::CMD_START, 0, 0, 3, 1, 'h1234, 1, 1, 1, 0, 0, 'h1234, 0));
    plan.push_back(adv_row());
    plan.push_back(adv_row());
    plan.push_back(adv_row());
    plan.push_back(row(blr_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1));
    plan.push_back(row(blr_pkg::CMD_START, 319, 479, 320, 480, 'h5555,
                       1, 1, 1, 319, 479, 'h5555, 0));
    plan.push_back(adv_row());
    plan.push_back(row(blr_pkg::CMD_START, -1, 0, 0, -1, 'h8000, 1, 1, 0, -1, 0, 'h8000, 0));
    plan.push_back(adv_row());
    plan.push_back(row(blr_pkg::CMD_START, 2, 0, 2, 3, 'h07E0, 1, 1, 1, 2, 0, 'h07E0, 0));
    plan.push_back(adv_row());
    plan.push_back(adv_row());
    plan.push_back(adv_row());
    plan.push_back(row(blr_pkg::CMD_START, 10, 10, 4, 8, 'hF800,
                       1, 1, 1, 10, 10, 'hF800, 0));
    plan.push_back(adv_row());
    plan.push_back(row(blr_pkg::CMD_START, 0, 0, -3, -9, 'h001F, 1, 1, 1, 0, 0, 'h001F, 0));
    plan.push_back(adv_row());
    plan.push_back(adv_row());

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < plan.size(); r++)
      send_beat(plan[r].cmd, plan[r].typed, plan[r].point);
    settle();

    // Random lines over a range of screen sizes; one phase runs without idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      steady = (p == 3);
      set_screen(phase_w[p], phase_h[p]);
      play_phase(PHASE_ITEMS, phase_w[p], phase_h[p]);
      settle();
    end

    if (mismatch_count == 0)
      $display("[bresenham_line_rasterizer] OK");
    else
      $display("[bresenham_line_rasterizer] ERROR");
    $finish;
  end

endmodule
